[sv/lsr_pkg.sv]
package lsr_pkg;

  // Coordinate width of the endpoints and of the emitted pixels.
  localparam int COORD_BITS = 12;
  // Spans between two coordinates need one more bit.
  localparam int DELTA_BITS = COORD_BITS + 1;
  // The rounding error holds up to four spans with sign.
  localparam int ERR_BITS = COORD_BITS + 3;
  // Configuration registers are as wide as a coordinate.
  localparam int CFG_BITS = COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_BITS-1:0] cfg_word_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } reg_index_t;

  localparam logic [CFG_BITS-1:0] CANVAS_WIDTH_RST  = CFG_BITS'(600);
  localparam logic [CFG_BITS-1:0] CANVAS_HEIGHT_RST = CFG_BITS'(600);

  typedef struct packed {
    cmd_t   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   inside_res;
    logic   last_pixel;
  } out_item_t;

endpackage

[sv/lsr_walker.sv]
module lsr_walker
  import lsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_item_t  item,
  input  cfg_word_t canvas_width,
  input  cfg_word_t canvas_height,
  output logic      res_valid,
  output out_item_t res
);

  logic                         line_active_r, line_active_nxt;
  logic                         walk_y_r, walk_y_nxt;
  coord_t                       major_pos_r, major_pos_nxt;
  coord_t                       major_end_r, major_end_nxt;
  coord_t                       minor_pos_r, minor_pos_nxt;
  logic        [DELTA_BITS-1:0] major_delta_r, major_delta_nxt;
  logic signed [DELTA_BITS-1:0] minor_delta_r, minor_delta_nxt;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt;

  logic signed [DELTA_BITS-1:0] dx, dy, adx, ady;
  logic                         steep, swap;
  coord_t                       a0, b0, a1, b1;
  logic signed [DELTA_BITS-1:0] span;
  logic signed [ERR_BITS-1:0]   two_major, err_sum;
  coord_t                       px, py;

  always_comb begin
    // Start: pick the major axis and order the endpoints along it.
    dx    = DELTA_BITS'(item.end_x) - DELTA_BITS'(item.start_x);
    dy    = DELTA_BITS'(item.end_y) - DELTA_BITS'(item.start_y);
    adx   = dx[DELTA_BITS-1] ? -dx : dx;
    ady   = dy[DELTA_BITS-1] ? -dy : dy;
    steep = ady > adx;
    if (steep) begin
      a0 = item.start_y; b0 = item.start_x; a1 = item.end_y; b1 = item.end_x;
    end else begin
      a0 = item.start_x; b0 = item.start_y; a1 = item.end_x; b1 = item.end_y;
    end
    swap = a0 > a1;
    if (swap) begin
      {a0, a1} = {a1, a0};
      {b0, b1} = {b1, b0};
    end
    span = DELTA_BITS'(a1) - DELTA_BITS'(a0);

    // Step: advance the major axis and correct the minor one by the error.
    two_major = {{(ERR_BITS-DELTA_BITS-1){1'b0}}, major_delta_r, 1'b0};
    err_sum   = err_r + {{(ERR_BITS-DELTA_BITS-1){minor_delta_r[DELTA_BITS-1]}},
                         minor_delta_r, 1'b0};

    line_active_nxt = line_active_r;
    walk_y_nxt      = walk_y_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    minor_pos_nxt   = minor_pos_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    err_nxt         = err_r;
    res_valid       = 1'b0;

    if (adv) begin
      if (item.command == CMD_START) begin
        walk_y_nxt      = steep;
        major_pos_nxt   = a0;
        major_end_nxt   = a1;
        minor_pos_nxt   = b0;
        major_delta_nxt = span;
        minor_delta_nxt = DELTA_BITS'(b1) - DELTA_BITS'(b0);
        err_nxt         = {{(ERR_BITS-DELTA_BITS){1'b0}}, span};
        line_active_nxt = a0 != a1;
        res_valid       = 1'b1;
      end else if (line_active_r) begin
        major_pos_nxt = major_pos_r + coord_t'(1);
        if (err_sum >= two_major) begin
          err_nxt       = err_sum - two_major;
          minor_pos_nxt = minor_pos_r + coord_t'(1);
        end else if (err_sum < 0) begin
          err_nxt       = err_sum + two_major;
          minor_pos_nxt = minor_pos_r - coord_t'(1);
        end else begin
          err_nxt = err_sum;
        end
        line_active_nxt = major_pos_nxt != major_end_r;
        res_valid       = 1'b1;
      end
    end

    px = walk_y_nxt ? minor_pos_nxt : major_pos_nxt;
    py = walk_y_nxt ? major_pos_nxt : minor_pos_nxt;
    res.pixel_x    = px;
    res.pixel_y    = py;
    res.inside_res = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                     (cfg_word_t'(px) < canvas_width) &&
                     (cfg_word_t'(py) < canvas_height);
    res.last_pixel = !line_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      walk_y_r      <= 1'b0;
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_pos_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      err_r         <= '0;
    end else begin
      line_active_r <= line_active_nxt;
      walk_y_r      <= walk_y_nxt;
      major_pos_r   <= major_pos_nxt;
      major_end_r   <= major_end_nxt;
      minor_pos_r   <= minor_pos_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

[sv/line_segment_rasterizer.sv]
// Line segment rasterizer. A start item carries two signed endpoints and
// yields the first pixel of the segment; each following step item yields the
// next pixel, one pixel per item, until the pixel marked last_pixel. The
// segment is walked along its longer axis in increasing coordinate order, and
// the other coordinate is the exact line value rounded half up, kept by an
// integer error term, so the result is exact with no fractions. Every pixel
// also says whether it lies inside the canvas set by the canvas_width and
// canvas_height registers (reset value 600 each). A step item while no line
// is running produces nothing, and a start item always drops a running line.
// The block takes one item per clock cycle while in_stall is low: an item
// is registered at the input, the walker updates its position and error
// term from it as it leaves the input register, and its pixel lands in the
// output register. A stall on the output backs up into in_stall only once
// both the output register and the input register hold an item. Canvas
// registers should be written only while no item is in flight.
module line_segment_rasterizer
  import lsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  reg_index_t cfg_index,
  input  cfg_word_t  cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  cfg_word_t canvas_width_r;
  cfg_word_t canvas_height_r;

  // Input register stage.
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_adv;

  // Output register stage.
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      walk_valid;
  out_item_t walk_res;

  // The held item moves on whenever the output register is empty or is being
  // taken in this same cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CANVAS_WIDTH_RST;
      canvas_height_r <= CANVAS_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  lsr_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (s1_adv),
    .item          (s1_item_r),
    .canvas_width  (canvas_width_r),
    .canvas_height (canvas_height_r),
    .res_valid     (walk_valid),
    .res           (walk_res)
  );

  // A step item with no running line advances but leaves the output empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= walk_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && walk_valid) begin
      out_item_r <= walk_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[sv/lsr_checker.sv]
module lsr_checker
  import lsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // The output register comes up empty after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // A pixel that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled pixel changed or vanished");

  // The input only backs up behind a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  // A start item always yields a pixel if the output moves while the item is held in the input register.
  a_start_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.command == CMD_START) ##1 !out_stall
    |=> out_valid)
    else $error("start item produced no pixel");

  // A pixel flagged inside has no negative coordinate.
  a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.inside_res |->
      !out_item.pixel_x[COORD_BITS-1] && !out_item.pixel_y[COORD_BITS-1])
    else $error("negative pixel flagged inside");

endmodule

bind line_segment_rasterizer lsr_checker u_lsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
